// ===== rtl/bfr_pkg.sv =====
// shared types and constants of the shortest path edge relaxer
package bfr_pkg;

    localparam int NODE_W     = 12;
    localparam int COUNT_W    = 13;
    localparam int WEIGHT_W   = 16;
    localparam int OUT_DIST_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd1;

    localparam logic [NODE_W-1:0]  SOURCE_NODE_RST = 12'd0;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RST  = 13'd4096;

    typedef enum logic [1:0] {
        ACT_RELAX = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CLR_IDLE,
        CLR_SWEEP,
        CLR_SOURCE
    } clr_state_t;

    typedef struct packed {
        action_t action;
        logic    eop;
        logic    from_ok;
        logic    to_ok;
        logic    hit_from;
        logic    hit_to;
    } s1_ctrl_t;

endpackage

// ===== rtl/bfr_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
module bfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/bfr_clear_seq.sv =====
// clear sequencer: sweeps the distance memory to unreachable, then zeroes the source
module bfr_clear_seq #(
    parameter int NODES     = 4096,
    parameter int DIST_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bfr_pkg::NODE_W-1:0]   source_node,
    input  logic [bfr_pkg::COUNT_W-1:0]  node_count,
    output logic                         busy,
    output logic                         we,
    output logic [$clog2(NODES)-1:0]     waddr,
    output logic [DIST_BITS-1:0]         wdata
);

    import bfr_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int IDX_W = ((AW > NODE_W) ? AW : NODE_W) + 1;
    localparam logic [IDX_W-1:0]     NODES_X  = IDX_W'(NODES);
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    clr_state_t       state_reg;
    clr_state_t       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [IDX_W-1:0] count_ext;
    logic [IDX_W-1:0] lim;
    logic [IDX_W-1:0] src_ext;
    logic [IDX_W-1:0] cnt_inc;

    assign count_ext = IDX_W'(node_count);
    assign lim       = (count_ext > NODES_X) ? NODES_X : count_ext;
    assign src_ext   = IDX_W'(source_node);
    assign cnt_inc   = cnt_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        we         = 1'b0;
        waddr      = cnt_reg[AW-1:0];
        wdata      = DIST_MAX;
        case (state_reg)
            CLR_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    state_next = (lim == '0) ? CLR_SOURCE : CLR_SWEEP;
                end
            end
            CLR_SWEEP:
            begin
                we       = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc == lim)
                begin
                    state_next = CLR_SOURCE;
                end
            end
            CLR_SOURCE:
            begin
                we         = src_ext < NODES_X;
                waddr      = src_ext[AW-1:0];
                wdata      = '0;
                state_next = CLR_IDLE;
            end
            default:
            begin
                state_next = CLR_IDLE;
            end
        endcase
    end

    assign busy = state_reg != CLR_IDLE;

endmodule

// ===== rtl/bfr_relax_pipe.sv =====
// command handshake, read-modify-write stage with forwarding, and response register
module bfr_relax_pipe #(
    parameter int NODES     = 4096,
    parameter int DIST_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [1:0]                      action,
    input  logic [bfr_pkg::NODE_W-1:0]      node_from,
    input  logic [bfr_pkg::NODE_W-1:0]      node_to,
    input  logic [bfr_pkg::WEIGHT_W-1:0]    weight,
    input  logic                            end_of_pass,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [bfr_pkg::OUT_DIST_W-1:0]  distance,
    output logic                            updated,
    output logic                            pass_changed,
    input  logic                            clr_busy,
    output logic                            clr_start,
    output logic                            rd_en,
    output logic [$clog2(NODES)-1:0]        rd_addr_a,
    output logic [$clog2(NODES)-1:0]        rd_addr_b,
    input  logic [DIST_BITS-1:0]            rd_data_a,
    input  logic [DIST_BITS-1:0]            rd_data_b,
    input  logic                            mem_we,
    input  logic [$clog2(NODES)-1:0]        mem_waddr,
    input  logic [DIST_BITS-1:0]            mem_wdata,
    output logic                            relax_we,
    output logic [$clog2(NODES)-1:0]        relax_waddr,
    output logic [DIST_BITS-1:0]            relax_wdata
);

    import bfr_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int IDX_W = ((AW > NODE_W) ? AW : NODE_W) + 1;
    localparam int SW    = ((DIST_BITS > WEIGHT_W) ? DIST_BITS : WEIGHT_W) + 1;
    localparam logic [IDX_W-1:0]     NODES_X  = IDX_W'(NODES);
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    logic                  accept;
    logic                  advance;
    logic                  fire;
    logic [IDX_W-1:0]      from_ext;
    logic [IDX_W-1:0]      to_ext;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    s1_ctrl_t              s1_ctrl_reg;
    s1_ctrl_t              s1_ctrl_next;
    logic [WEIGHT_W-1:0]   s1_weight_reg;
    logic [AW-1:0]         s1_to_addr_reg;
    logic [DIST_BITS-1:0]  s1_fwd_reg;

    logic                  flag_reg;
    logic                  flag_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DIST_W-1:0] out_dist_reg;
    logic                  out_upd_reg;
    logic                  out_pchg_reg;

    logic [DIST_BITS-1:0]  d1;
    logic [DIST_BITS-1:0]  d2;
    logic [SW-1:0]         sum_w;
    logic [DIST_BITS-1:0]  sum;
    logic                  upd;
    logic [DIST_BITS-1:0]  res_dist;
    logic                  res_upd;
    logic                  res_pchg;

    assign advance   = !out_valid_reg || !rsp_stall;
    assign cmd_stall = clr_busy || (s1_valid_reg && !advance);
    assign accept    = cmd_valid && !cmd_stall;
    assign fire      = s1_valid_reg && advance;

    assign from_ext  = IDX_W'(node_from);
    assign to_ext    = IDX_W'(node_to);
    assign rd_en     = accept;
    assign rd_addr_a = from_ext[AW-1:0];
    assign rd_addr_b = to_ext[AW-1:0];
    assign clr_start = accept && (action_t'(action) == ACT_CLEAR);

    always_comb
    begin
        s1_ctrl_next.action   = action_t'(action);
        s1_ctrl_next.eop      = end_of_pass;
        s1_ctrl_next.from_ok  = from_ext < NODES_X;
        s1_ctrl_next.to_ok    = to_ext < NODES_X;
        // catch the write landing on the same edge as the read
        s1_ctrl_next.hit_from = mem_we && (mem_waddr == rd_addr_a);
        s1_ctrl_next.hit_to   = mem_we && (mem_waddr == rd_addr_b);
        s1_valid_next         = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg    <= s1_ctrl_next;
            s1_weight_reg  <= weight;
            s1_to_addr_reg <= rd_addr_b;
            s1_fwd_reg     <= mem_wdata;
        end
        if (fire)
        begin
            out_dist_reg <= OUT_DIST_W'(res_dist);
            out_upd_reg  <= res_upd;
            out_pchg_reg <= res_pchg;
        end
    end

    // relax datapath
    always_comb
    begin
        if (!s1_ctrl_reg.from_ok)
        begin
            d1 = DIST_MAX;
        end
        else if (s1_ctrl_reg.hit_from)
        begin
            d1 = s1_fwd_reg;
        end
        else
        begin
            d1 = rd_data_a;
        end
        if (!s1_ctrl_reg.to_ok)
        begin
            d2 = DIST_MAX;
        end
        else if (s1_ctrl_reg.hit_to)
        begin
            d2 = s1_fwd_reg;
        end
        else
        begin
            d2 = rd_data_b;
        end
        sum_w = SW'(d1) + SW'(s1_weight_reg);
        sum   = (sum_w > SW'(DIST_MAX)) ? DIST_MAX : sum_w[DIST_BITS-1:0];
        upd   = (d1 != DIST_MAX) && (d2 > sum) && s1_ctrl_reg.to_ok;
    end

    always_comb
    begin
        res_dist  = '0;
        res_upd   = 1'b0;
        res_pchg  = 1'b0;
        flag_next = flag_reg;
        relax_we  = 1'b0;
        case (s1_ctrl_reg.action)
            ACT_RELAX:
            begin
                res_dist = upd ? sum : d2;
                res_upd  = upd;
                relax_we = fire && upd;
                if (fire)
                begin
                    if (s1_ctrl_reg.eop)
                    begin
                        res_pchg  = flag_reg || upd;
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        flag_next = flag_reg || upd;
                    end
                end
            end
            ACT_READ:
            begin
                res_dist = d1;
            end
            ACT_CLEAR:
            begin
                if (fire)
                begin
                    flag_next = 1'b0;
                end
            end
            default:
            begin
                res_dist = '0;
            end
        endcase
    end

    assign relax_waddr = s1_to_addr_reg;
    assign relax_wdata = sum;

    assign out_valid_next = fire ? 1'b1 : (rsp_stall ? out_valid_reg : 1'b0);

    assign rsp_valid    = out_valid_reg;
    assign distance     = out_dist_reg;
    assign updated      = out_upd_reg;
    assign pass_changed = out_pchg_reg;

endmodule

// ===== rtl/bellman_ford_edge_relaxer_top.sv =====
// top level of the shortest path edge relaxer
// response: a relax, read or clear transaction passes stage s1, then the response register
// throughput: one relax or read per unstalled cycle, set by one read-modify-write stage
// clear: sweeps min(node_count, NODES) entries and the source; no command taken meanwhile
// reset: control state and configuration registers clear; distance memory is undefined until
// the first clear
module bellman_ford_edge_relaxer_top #(
    parameter int NODES     = 4096,
    parameter int DIST_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfr_pkg::COUNT_W-1:0]       cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        action,
    input  logic [bfr_pkg::NODE_W-1:0]        node_from,
    input  logic [bfr_pkg::NODE_W-1:0]        node_to,
    input  logic [bfr_pkg::WEIGHT_W-1:0]      weight,
    input  logic                              end_of_pass,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [bfr_pkg::OUT_DIST_W-1:0]    distance,
    output logic                              updated,
    output logic                              pass_changed
);

    import bfr_pkg::*;

    localparam int AW = $clog2(NODES);

    logic [NODE_W-1:0]    source_node_reg;
    logic [COUNT_W-1:0]   node_count_reg;

    logic                 clr_busy;
    logic                 clr_start;
    logic                 clr_we;
    logic [AW-1:0]        clr_waddr;
    logic [DIST_BITS-1:0] clr_wdata;
    logic                 relax_we;
    logic [AW-1:0]        relax_waddr;
    logic [DIST_BITS-1:0] relax_wdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DIST_BITS-1:0] mem_wdata;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [DIST_BITS-1:0] rd_data_a;
    logic [DIST_BITS-1:0] rd_data_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_node_reg <= SOURCE_NODE_RST;
            node_count_reg  <= NODE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_NODE: source_node_reg <= cfg_data[NODE_W-1:0];
                REG_NODE_COUNT:  node_count_reg  <= cfg_data;
                default:         node_count_reg  <= node_count_reg;
            endcase
        end
    end

    assign mem_we    = clr_we || relax_we;
    assign mem_waddr = clr_we ? clr_waddr : relax_waddr;
    assign mem_wdata = clr_we ? clr_wdata : relax_wdata;

    bfr_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (NODES)
    ) u_dist_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd_data_a),
        .rdata_b (rd_data_b)
    );

    bfr_clear_seq #(
        .NODES     (NODES),
        .DIST_BITS (DIST_BITS)
    ) u_clear (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (clr_start),
        .source_node (source_node_reg),
        .node_count  (node_count_reg),
        .busy        (clr_busy),
        .we          (clr_we),
        .waddr       (clr_waddr),
        .wdata       (clr_wdata)
    );

    bfr_relax_pipe #(
        .NODES     (NODES),
        .DIST_BITS (DIST_BITS)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .action       (action),
        .node_from    (node_from),
        .node_to      (node_to),
        .weight       (weight),
        .end_of_pass  (end_of_pass),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .distance     (distance),
        .updated      (updated),
        .pass_changed (pass_changed),
        .clr_busy     (clr_busy),
        .clr_start    (clr_start),
        .rd_en        (rd_en),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .relax_we     (relax_we),
        .relax_waddr  (relax_waddr),
        .relax_wdata  (relax_wdata)
    );

endmodule

// ===== rtl/bfr_checker.sv =====
// port-level checker for the edge relaxer and its bind
module bfr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_stall,
    input  logic [1:0]                        action,
    input  logic                              rsp_valid,
    input  logic                              rsp_stall,
    input  logic [bfr_pkg::OUT_DIST_W-1:0]    distance,
    input  logic                              updated,
    input  logic                              pass_changed
);

    import bfr_pkg::*;

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(distance) && $stable(updated)
            && $stable(pass_changed))
    else $error("response changed while stalled");

    // clear sweep blocks the command channel
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (action == ACT_CLEAR) |=> cmd_stall)
    else $error("command taken during clear sweep");

    // only one transaction fits behind a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall && cmd_valid && !cmd_stall) ##1 rsp_stall |-> cmd_stall)
    else $error("command taken with pipeline full");

    // a response never appears without an earlier transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_stall || rsp_valid, 2) || $past(rsp_valid))
    else $error("response without command");

endmodule

bind bellman_ford_edge_relaxer_top bfr_checker u_bfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .action       (action),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .distance     (distance),
    .updated      (updated),
    .pass_changed (pass_changed)
);

// ===== tb/bellman_ford_edge_relaxer_top_tb.sv =====
// self-checking testbench of the shortest path edge relaxer top level
module bellman_ford_edge_relaxer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfr_pkg::*;

    localparam int NODES = 4096;
    localparam logic [OUT_DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SWEEP_PAUSE = 4200;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [OUT_DIST_W-1:0] dist_val;
        logic                  upd;
        logic                  pchg;
    } rsp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COUNT_W-1:0]    cfg_data;
    logic                  cmd_valid;
    logic                  cmd_stall;
    logic [1:0]            action;
    logic [NODE_W-1:0]     node_from;
    logic [NODE_W-1:0]     node_to;
    logic [WEIGHT_W-1:0]   weight;
    logic                  end_of_pass;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [OUT_DIST_W-1:0] distance;
    logic                  updated;
    logic                  pass_changed;

    // predictor state
    logic [OUT_DIST_W-1:0] dist_model [NODES];
    logic                  pass_flag;
    logic [NODE_W-1:0]     cfg_source;
    logic [COUNT_W-1:0]    cfg_count;

    rsp_t pending_rsp [$];
    int   err_count = 0;
    int   send_idle = 20;
    int   recv_idle = 30;
    int   hold_left = 0;
    int   cyc;

    bellman_ford_edge_relaxer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .action       (action),
        .node_from    (node_from),
        .node_to      (node_to),
        .weight       (weight),
        .end_of_pass  (end_of_pass),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .distance     (distance),
        .updated      (updated),
        .pass_changed (pass_changed)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic rsp_t compute_response(logic [1:0] act, logic [NODE_W-1:0] from,
                                              logic [NODE_W-1:0] to, logic [WEIGHT_W-1:0] w,
                                              logic eop);
        rsp_t                  r;
        logic [OUT_DIST_W:0]   sum;
        logic [OUT_DIST_W-1:0] d_from;
        logic [OUT_DIST_W-1:0] d_to;
        logic [OUT_DIST_W-1:0] total;
        int                    n;
        r = '0;
        case (act)
            ACT_RELAX:
            begin
                d_from = dist_model[from];
                d_to = dist_model[to];
                if (d_from != DIST_MAX)
                begin
                    sum = {1'b0, d_from} + {17'd0, w};
                    total = sum[OUT_DIST_W] ? DIST_MAX : sum[OUT_DIST_W-1:0];
                    if (d_to > total)
                    begin
                        dist_model[to] = total;
                        d_to = total;
                        r.upd = 1'b1;
                    end
                end
                r.dist_val = d_to;
                if (r.upd)
                    pass_flag = 1'b1;
                if (eop)
                begin
                    r.pchg = pass_flag;
                    pass_flag = 1'b0;
                end
            end
            ACT_READ:
                r.dist_val = dist_model[from];
            ACT_CLEAR:
            begin
                n = (int'(cfg_count) > NODES) ? NODES : int'(cfg_count);
                for (int i = 0; i < n; i++)
                    dist_model[i] = DIST_MAX;
                dist_model[cfg_source] = '0;
                pass_flag = 1'b0;
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [OUT_DIST_W-1:0] exp_v,
                               logic [OUT_DIST_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("response transaction with nothing pending: distance %0h", distance);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("distance", want.dist_val, distance);
                check_field("updated", 32'(want.upd), 32'(updated));
                check_field("pass_changed", 32'(want.pchg), 32'(pass_changed));
            end
        end
    end

    // receiver backpressure, with an optional long hold
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_SOURCE_NODE)
            cfg_source = val[NODE_W-1:0];
        else if (idx == REG_NODE_COUNT)
            cfg_count = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_cmd(logic [1:0] act, logic [NODE_W-1:0] from, logic [NODE_W-1:0] to,
                            logic [WEIGHT_W-1:0] w, logic eop);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        action <= act;
        node_from <= from;
        node_to <= to;
        weight <= w;
        end_of_pass <= eop;
        do @(posedge clk); while (cmd_stall);
        pending_rsp.push_back(compute_response(act, from, to, w, eop));
        @(negedge clk);
    endtask

    task automatic send_edge(logic [NODE_W-1:0] from, logic [NODE_W-1:0] to,
                             logic [WEIGHT_W-1:0] w, logic eop);
        send_cmd(ACT_RELAX, from, to, w, eop);
    endtask

    task automatic read_node(logic [NODE_W-1:0] node);
        send_cmd(ACT_READ, node, '0, '0, 1'b0);
    endtask

    task automatic clear_nodes();
        send_cmd(ACT_CLEAR, '0, '0, '0, 1'b0);
    endtask

    // drain all responses, then let any clear sweep finish
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SWEEP_PAUSE) @(negedge clk);
    endtask

    task automatic test_first_clear();
        send_cmd(ACT_UNUSED, '1, '1, '1, 1'b1);
        clear_nodes();
        read_node(12'd0);
        read_node(12'd4095);
        wait_idle();
    endtask

    task automatic test_pass_flag();
        send_edge(12'd4095, 12'd1, 16'd5, 1'b0);
        send_edge(12'd0, 12'd1, 16'hFFFF, 1'b0);
        send_edge(12'd0, 12'd1, 16'd0, 1'b0);
        send_edge(12'd1, 12'd1, 16'd0, 1'b1);
        send_edge(12'd0, 12'd1, 16'd7, 1'b1);
        send_edge(12'd0, 12'd3, 16'd9, 1'b0);
        send_cmd(ACT_READ, 12'd3, 12'd0, 16'd0, 1'b1);
        send_edge(12'd3, 12'd4, 16'd1, 1'b1);
        send_edge(12'd0, 12'd5, 16'd3, 1'b0);
        clear_nodes();
        send_edge(12'd0, 12'd0, 16'd0, 1'b1);
        read_node(12'd5);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_SOURCE_NODE, 13'd4095);
        write_reg(REG_NODE_COUNT, 13'd8191);
        clear_nodes();
        read_node(12'd4095);
        read_node(12'd0);
        send_edge(12'd4095, 12'd0, 16'hFFFF, 1'b1);
        wait_idle();
        write_reg(REG_SOURCE_NODE, 13'd7);
        write_reg(REG_NODE_COUNT, 13'd0);
        clear_nodes();
        read_node(12'd7);
        read_node(12'd0);
        wait_idle();
        write_reg(REG_SOURCE_NODE, 13'd0);
        write_reg(REG_NODE_COUNT, 13'd1);
        clear_nodes();
        read_node(12'd0);
        read_node(12'd7);
        read_node(12'd4095);
        wait_idle();
    endtask

    task automatic test_random_traffic(int snd_pct, int rcv_pct, int n_items);
        int                  count;
        int                  win;
        int                  len;
        int                  reps;
        int                  r;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   e_from [16];
        logic [NODE_W-1:0]   e_to [16];
        logic [WEIGHT_W-1:0] e_w [16];
        send_idle = snd_pct;
        recv_idle = rcv_pct;
        win = $urandom_range(8, 40);
        src = NODE_W'($urandom_range(0, win - 1));
        write_reg(REG_SOURCE_NODE, COUNT_W'(src));
        write_reg(REG_NODE_COUNT, COUNT_W'(win + $urandom_range(0, 8)));
        clear_nodes();
        count = 1;
        while (count < n_items)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_cmd(2'($urandom_range(0, 3)), NODE_W'($urandom), NODE_W'($urandom),
                         WEIGHT_W'($urandom), 1'($urandom));
                count++;
            end
            else if (r < 12)
            begin
                read_node(NODE_W'($urandom_range(0, win - 1)));
                count++;
            end
            else if (r < 14)
            begin
                clear_nodes();
                count++;
            end
            else
            begin
                len = $urandom_range(3, 12);
                reps = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 40)
                        e_from[i] = (i == 0) ? src : e_to[i-1];
                    else
                        e_from[i] = NODE_W'($urandom_range(0, win - 1));
                    e_to[i] = NODE_W'($urandom_range(0, win - 1));
                    e_w[i] = ($urandom_range(99) < 80) ? WEIGHT_W'($urandom_range(0, 255))
                                                       : WEIGHT_W'($urandom);
                end
                for (int p = 0; p < reps; p++)
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        send_edge(e_from[i], e_to[i], e_w[i], i == len - 1);
                        count++;
                        if ($urandom_range(99) < 8)
                        begin
                            read_node(NODE_W'($urandom_range(0, win - 1)));
                            count++;
                        end
                    end
                end
            end
        end
        wait_idle();
    endtask

    task automatic test_stalled_receiver();
        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_NODE_COUNT, 13'd4096);
        write_reg(REG_SOURCE_NODE, 13'd3);
        clear_nodes();
        wait_idle();
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        for (int i = 0; i < 60; i++)
        begin
            if (i % 5 == 4)
                read_node(NODE_W'(3 + i / 2));
            else
                send_edge(NODE_W'(3 + i / 2), NODE_W'(4 + i / 2),
                          WEIGHT_W'($urandom_range(0, 100)), i % 10 == 9);
        end
        wait_idle();
    endtask

    initial
    begin
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("bellman_ford_edge_relaxer_top_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_valid = 1'b0;
        action = '0;
        node_from = '0;
        node_to = '0;
        weight = '0;
        end_of_pass = 1'b0;
        rsp_stall = 1'b0;
        pass_flag = 1'b0;
        cfg_source = SOURCE_NODE_RST;
        cfg_count = NODE_COUNT_RST;
        for (int i = 0; i < NODES; i++)
            dist_model[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        test_first_clear();
        test_pass_flag();
        test_config_extremes();
        test_random_traffic(37, 66, 520);
        test_random_traffic(66, 37, 520);
        test_random_traffic(0, 0, 520);
        test_stalled_receiver();

        wait_idle();
        if (err_count == 0)
            $display("bellman_ford_edge_relaxer_top_tb: clean");
        else
            $display("bellman_ford_edge_relaxer_top_tb: errors");
        $finish;
    end

endmodule

// ===== bellman_ford_edge_relaxer_top.f =====
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bfr_clear_seq.sv
rtl/bfr_relax_pipe.sv
rtl/bellman_ford_edge_relaxer_top.sv
rtl/bfr_checker.sv
tb/bellman_ford_edge_relaxer_top_tb.sv
